// ----- rtl/wpm_pkg.sv -----
// Package for the wildcard pattern matcher: item structs, operation codes,
// the token passed between cells and the wildcard symbol constants.
// No dependencies.
package wpm_pkg;

  localparam logic [7:0] SYM_ANY_ONE = 8'd63;
  localparam logic [7:0] SYM_ANY_RUN = 8'd42;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEXT   = 2'd2
  } mode_t;

  typedef struct packed {
    logic       command;
    logic [7:0] symbol;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_item_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] symbol;
    logic       rebuild;
  } op_t;

  typedef struct packed {
    logic vld;
    logic old_prev;
    logic new_prev;
    logic res;
  } tok_t;

endpackage

// ----- rtl/wpm_cell.sv -----
// One cell of the matcher row: holds one pattern character and one match bit.
// Depends on wpm_pkg for op_t, tok_t and the wildcard symbols.
// Updates when the token from its left neighbor arrives and passes it right.
module wpm_cell #(
  parameter int PATTERN_MAX = 64,
  parameter int K           = 0,
  localparam int LW         = $clog2(PATTERN_MAX + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  wpm_pkg::op_t  op,
  input  logic [LW-1:0] wr_idx,
  input  logic [LW-1:0] len,
  input  wpm_pkg::tok_t tok_in,
  output wpm_pkg::tok_t tok_out
);

  logic [7:0]    char_r;
  logic          match_r;
  wpm_pkg::tok_t tok_r;
  logic          is_wr;
  logic          in_use;
  logic [7:0]    ch;
  logic          star;
  logic          any;
  logic          old_here;
  logic          match_nxt;
  wpm_pkg::tok_t tok_nxt;

  assign is_wr  = (op.mode == wpm_pkg::MODE_APPEND) && (wr_idx == LW'(K));
  assign in_use = LW'(K) < len;
  assign ch     = is_wr ? op.symbol : char_r;
  assign star   = ch == wpm_pkg::SYM_ANY_RUN;
  assign any    = ch == wpm_pkg::SYM_ANY_ONE;

  always_comb begin
    old_here  = match_r;
    match_nxt = match_r;
    case (op.mode)
      wpm_pkg::MODE_APPEND: begin
        match_nxt = in_use & tok_in.new_prev & star;
      end
      wpm_pkg::MODE_TEXT: begin
        if (op.rebuild) begin
          old_here = in_use & tok_in.old_prev & star;
        end
        match_nxt = in_use & (((any | star | (ch == op.symbol)) & tok_in.old_prev) |
                              (star & (old_here | tok_in.new_prev)));
      end
      default: begin
        match_nxt = match_r;
      end
    endcase
    tok_nxt.vld      = tok_in.vld;
    tok_nxt.old_prev = old_here;
    tok_nxt.new_prev = match_nxt;
    tok_nxt.res      = (len == LW'(K + 1)) ? match_nxt : tok_in.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
      if (tok_in.vld) begin
        match_r <= match_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.vld) begin
      tok_r.old_prev <= tok_nxt.old_prev;
      tok_r.new_prev <= tok_nxt.new_prev;
      tok_r.res      <= tok_nxt.res;
      if (is_wr) begin
        char_r <= op.symbol;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- rtl/wildcard_pattern_matcher_core.sv -----
// Wildcard pattern matcher top level: decodes items, drives the cell row,
// and buffers results. Depends on wpm_pkg and wpm_cell.
//
// Usage: in_item carries command (0 append pattern character, 1 text
// character), symbol and first. Each accepted item yields exactly one out_item
// with matched (whole pattern matches whole text so far) and overflow (pattern
// character dropped because PATTERN_MAX characters are already stored).
// An item is taken when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// Each item sends one token down the row of PATTERN_MAX cells, one cell per
// cycle, and the block takes no new item until that token has left the row:
// in_stall stays high while a token is in the row.
// A result waiting under out_stall does not block the next item: a second
// result slot holds the following result, and in_stall also stays high while
// that slot is full.
// Reset (rst_n low, synchronous) empties the pattern, sets the column to the
// empty-text state and drops any pending results.
module wildcard_pattern_matcher_core #(
  parameter int PATTERN_MAX = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wpm_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wpm_pkg::out_item_t   out_item
);

  localparam int LW = $clog2(PATTERN_MAX + 1);

  logic               busy_r;
  logic [LW-1:0]      len_r;
  logic               m0_r;
  wpm_pkg::op_t       op_r;
  logic [LW-1:0]      wr_idx_r;
  logic               dropped_r;
  wpm_pkg::tok_t      start_tok_r;
  logic               out_valid_r;
  wpm_pkg::out_item_t out_item_r;
  logic               pend_vld_r;
  wpm_pkg::out_item_t pend_item_r;

  wpm_pkg::tok_t      tok [PATTERN_MAX+1];

  logic               in_acc;
  logic               out_acc;
  logic [LW-1:0]      len_eff;
  logic [LW-1:0]      len_nxt;
  wpm_pkg::op_t       op_nxt;
  logic               dropped_nxt;
  logic               old0;
  logic               new0;
  wpm_pkg::out_item_t res_item;
  logic               wave_end;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign in_stall = busy_r || pend_vld_r;
  assign wave_end = tok[PATTERN_MAX].vld;

  always_comb begin
    len_eff        = in_item.first ? '0 : len_r;
    len_nxt        = len_r;
    dropped_nxt    = 1'b0;
    op_nxt.symbol  = in_item.symbol;
    op_nxt.rebuild = in_item.first;
    op_nxt.mode    = wpm_pkg::MODE_TEXT;
    old0           = in_item.first ? 1'b1 : m0_r;
    new0           = 1'b0;
    if (in_item.command == wpm_pkg::CMD_PATTERN) begin
      old0 = m0_r;
      if (len_eff < LW'(PATTERN_MAX)) begin
        op_nxt.mode = wpm_pkg::MODE_APPEND;
        len_nxt     = len_eff + LW'(1);
        new0        = 1'b1;
      end else begin
        op_nxt.mode = wpm_pkg::MODE_HOLD;
        dropped_nxt = 1'b1;
        new0        = m0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= 1'b0;
      len_r           <= '0;
      m0_r            <= 1'b1;
      start_tok_r.vld <= 1'b0;
    end else begin
      start_tok_r.vld <= in_acc;
      if (in_acc) begin
        busy_r <= 1'b1;
        len_r  <= len_nxt;
        m0_r   <= new0;
      end else if (wave_end) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r                 <= op_nxt;
      wr_idx_r             <= len_eff;
      dropped_r            <= dropped_nxt;
      start_tok_r.old_prev <= old0;
      start_tok_r.new_prev <= new0;
      start_tok_r.res      <= (len_nxt == '0) ? new0 : 1'b0;
    end
  end

  assign tok[0] = start_tok_r;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    wpm_cell #(
      .PATTERN_MAX (PATTERN_MAX),
      .K           (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op_r),
      .wr_idx  (wr_idx_r),
      .len     (len_r),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  assign res_item.matched  = tok[PATTERN_MAX].res;
  assign res_item.overflow = dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      if (wave_end && out_valid_r && out_stall) begin
        pend_vld_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= wave_end || pend_vld_r;
        pend_vld_r  <= 1'b0;
      end else if (wave_end) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wave_end && out_valid_r && out_stall) begin
      pend_item_r <= res_item;
    end else if (out_acc && pend_vld_r) begin
      out_item_r <= pend_item_r;
    end else if (wave_end && (!out_valid_r || !out_stall)) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("item accepted but row not busy");

  a_wave_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wave_end |-> busy_r)
    else $error("token left row while idle");

  a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> out_valid_r)
    else $error("pending result without output result");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_no_wave_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> !busy_r)
    else $error("row busy while pending slot full");

endmodule
